[hdl/bdasc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdasc_pkg
// Shared types and constants for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
package bdasc_pkg;

  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned CHAR_W     = 6;
  localparam int unsigned NUM_CELLS  = 4;
  localparam int unsigned NUM_DIGITS = NUM_CELLS + 1;
  localparam int unsigned POS_W      = 3;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'h30;
  localparam logic [CHAR_W-1:0] ASCII_NINE = 6'h39;

  // place weight handled by each cell, most significant first
  localparam int unsigned PLACE_WEIGHT [NUM_CELLS] = '{10000, 1000, 100, 10};

  typedef struct packed {
    logic [NUM_CELLS-1:0][DIGIT_W-1:0] digits;
    logic [VALUE_W-1:0]                rest;
  } item_t;

endpackage

[hdl/bdasc_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdasc_cell
// One digit cell: pulls one decimal digit out of the running remainder and
// hands the remainder on to the next cell.
// ----------------------------------------------------------------------------
module bdasc_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             up_valid,
  output logic             up_ready,
  input  bdasc_pkg::item_t up_item,
  output logic             dn_valid,
  input  logic             dn_ready,
  output bdasc_pkg::item_t dn_item
);

  localparam int unsigned Weight = bdasc_pkg::PLACE_WEIGHT[IDX];

  logic                            valid;
  bdasc_pkg::item_t                item;
  bdasc_pkg::item_t                item_next;
  logic [bdasc_pkg::DIGIT_W-1:0]   dig;
  logic [bdasc_pkg::VALUE_W:0]     sub;
  logic [bdasc_pkg::VALUE_W:0]     rem;

  // largest multiple of the weight that fits the remainder
  always_comb begin
    dig = '0;
    sub = '0;
    for (int m = 1; m <= 9; m++) begin
      if ({1'b0, up_item.rest} >= (bdasc_pkg::VALUE_W + 1)'(m * Weight)) begin
        dig = bdasc_pkg::DIGIT_W'(m);
        sub = (bdasc_pkg::VALUE_W + 1)'(m * Weight);
      end
    end
    rem = {1'b0, up_item.rest} - sub;
    item_next             = up_item;
    item_next.digits[IDX] = dig;
    item_next.rest        = rem[bdasc_pkg::VALUE_W-1:0];
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

  assign dn_valid = valid;
  assign dn_item  = item;

endmodule

[hdl/bdasc_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdasc_emit
// Output stage: holds the five digits of one value and sends them out one
// character per transaction, skipping leading zeros.
// ----------------------------------------------------------------------------
module bdasc_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  bdasc_pkg::item_t              up_item,
  output logic                          char_valid,
  input  logic                          char_stall,
  output logic [bdasc_pkg::CHAR_W-1:0]  char_code,
  output logic                          last_char
);

  logic [bdasc_pkg::DIGIT_W-1:0] dig [bdasc_pkg::NUM_DIGITS];
  logic [bdasc_pkg::POS_W-1:0]   pos;
  logic [bdasc_pkg::POS_W-1:0]   first;
  logic                          busy;
  logic                          take;
  logic                          last;

  // first nonzero digit, the units digit always goes out
  always_comb begin
    first = bdasc_pkg::POS_W'(bdasc_pkg::NUM_DIGITS - 1);
    for (int k = bdasc_pkg::NUM_CELLS - 1; k >= 0; k--) begin
      if (up_item.digits[k] != '0) begin
        first = bdasc_pkg::POS_W'(k);
      end
    end
  end

  assign last     = (pos == bdasc_pkg::POS_W'(bdasc_pkg::NUM_DIGITS - 1));
  assign take     = busy && !char_stall;
  assign up_ready = !busy || (take && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else if (up_valid && up_ready) begin
      busy <= 1'b1;
      pos  <= first;
    end else if (take) begin
      if (last) begin
        busy <= 1'b0;
      end else begin
        pos <= pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (up_valid && up_ready) begin
      for (int k = 0; k < bdasc_pkg::NUM_CELLS; k++) begin
        dig[k] <= up_item.digits[k];
      end
      dig[bdasc_pkg::NUM_DIGITS-1] <= up_item.rest[bdasc_pkg::DIGIT_W-1:0];
    end
  end

  assign char_valid = busy;
  assign char_code  = bdasc_pkg::ASCII_ZERO + {2'b00, dig[pos]};
  assign last_char  = last;

endmodule

[hdl/binary_to_decimal_ascii.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// 16-bit unsigned value to decimal ascii digits, most significant first,
// leading zeros suppressed, last_char flags the units digit.
// ----------------------------------------------------------------------------
//
// channel   direction  handshake                payload
// value     in         value_valid/value_stall  value[15:0]
// char      out        char_valid/char_stall    char_code[5:0], last_char
//
// a value passes through four digit cells in turn, then the output stage
// sends one character per cycle while char_stall is low, as many characters
// per value as the value has digits (1 to 5). later values queue in the cells.
// rst (synchronous) empties the cells and the output stage.
// char_stall holds the current character and backs up the cells in turn.
//
module binary_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          value_valid,
  output logic                          value_stall,
  input  logic [bdasc_pkg::VALUE_W-1:0] value,
  output logic                          char_valid,
  input  logic                          char_stall,
  output logic [bdasc_pkg::CHAR_W-1:0]  char_code,
  output logic                          last_char
);

  logic             stage_valid [bdasc_pkg::NUM_CELLS+1];
  logic             stage_ready [bdasc_pkg::NUM_CELLS+1];
  bdasc_pkg::item_t stage_item  [bdasc_pkg::NUM_CELLS+1];

  assign stage_valid[0]       = value_valid;
  assign stage_item[0].rest   = value;
  assign stage_item[0].digits = '0;
  assign value_stall          = !stage_ready[0];

  for (genvar g = 0; g < bdasc_pkg::NUM_CELLS; g++) begin : g_cell
    bdasc_cell #(
      .IDX(g)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (stage_valid[g]),
      .up_ready (stage_ready[g]),
      .up_item  (stage_item[g]),
      .dn_valid (stage_valid[g+1]),
      .dn_ready (stage_ready[g+1]),
      .dn_item  (stage_item[g+1])
    );
  end

  bdasc_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (stage_valid[bdasc_pkg::NUM_CELLS]),
    .up_ready   (stage_ready[bdasc_pkg::NUM_CELLS]),
    .up_item    (stage_item[bdasc_pkg::NUM_CELLS]),
    .char_valid (char_valid),
    .char_stall (char_stall),
    .char_code  (char_code),
    .last_char  (last_char)
  );

endmodule

[hdl/bdasc_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bdasc_checker
// Port level checks for the binary to decimal ascii converter.
// ----------------------------------------------------------------------------
module bdasc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          value_valid,
  input logic                          value_stall,
  input logic [bdasc_pkg::VALUE_W-1:0] value,
  input logic                          char_valid,
  input logic                          char_stall,
  input logic [bdasc_pkg::CHAR_W-1:0]  char_code,
  input logic                          last_char
);

  // reset empties the output side
  a_reset_idle: assert property (@(posedge clk) rst |=> !char_valid)
    else $error("character valid right after reset");

  // only decimal digit characters go out
  a_digit_range: assert property (@(posedge clk) disable iff (rst)
    char_valid |-> (char_code >= bdasc_pkg::ASCII_ZERO) && (char_code <= bdasc_pkg::ASCII_NINE))
    else $error("character is not a decimal digit");

  // digits of one number go out with no gap
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    char_valid && !char_stall && !last_char |=> char_valid)
    else $error("gap inside a number");

  // a stalled transaction keeps its payload
  a_hold: assert property (@(posedge clk) disable iff (rst)
    char_valid && char_stall |=> char_valid && $stable(char_code) && $stable(last_char))
    else $error("stalled character changed");

  // a stalled value waits unchanged until taken
  a_value_hold: assert property (@(posedge clk) disable iff (rst)
    value_valid && value_stall |=> value_valid && $stable(value))
    else $error("stalled value changed");

endmodule

bind binary_to_decimal_ascii bdasc_checker u_checker (.*);

[bench/binary_to_decimal_ascii_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii_tb
// Sends 16-bit values through the converter and checks every ascii digit that
// comes back, in order, against an expected character queue. A directed table
// covers decade edges and extremes, then random values weighted by digit
// count follow, with random gaps on the value side and random char stalls.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii_tb;

  localparam int unsigned N_RANDOM  = 200;
  localparam int unsigned N_ROWS    = 22;
  localparam int unsigned DRAIN_CYC = 20;

  typedef struct packed {
    logic [bdasc_pkg::CHAR_W-1:0] code;
    logic                         last;
  } digit_char_t;

  // txt holds the expected digits as a right-aligned string, zero means the row
  // is checked against the digits that push_decimal_chars computes instead
  typedef struct packed {
    logic [bdasc_pkg::VALUE_W-1:0] val;
    logic [39:0]                   txt;
  } stim_row_t;

  logic                          clk         = 1'b0;
  logic                          rst         = 1'b1;
  logic                          value_valid = 1'b0;
  logic                          value_stall;
  logic [bdasc_pkg::VALUE_W-1:0] value       = '0;
  logic                          char_valid;
  logic                          char_stall  = 1'b0;
  logic [bdasc_pkg::CHAR_W-1:0]  char_code;
  logic                          last_char;

  digit_char_t pending_chars [$];
  int unsigned err_count     = 0;
  int unsigned values_sent   = 0;
  int unsigned chars_checked = 0;
  int unsigned width_seen [1:5] = '{0, 0, 0, 0, 0};
  int unsigned stall_left    = 0;
  bit          quiet         = 1'b0;

  stim_row_t dir_rows [N_ROWS] = '{
    '{16'd0,     "0"},
    '{16'd65535, "65535"},
    '{16'd1,     "1"},
    '{16'd9,     "9"},
    '{16'd10,    "10"},
    '{16'd99,    "99"},
    '{16'd100,   "100"},
    '{16'd999,   "999"},
    '{16'd1000,  "1000"},
    '{16'd9999,  "9999"},
    '{16'd10000, "10000"},
    '{16'd65534, 40'd0},
    '{16'd32768, 40'd0},
    '{16'd12345, 40'd0},
    '{16'd10101, 40'd0},
    '{16'd50005, 40'd0},
    '{16'd43690, 40'd0},
    '{16'd21845, 40'd0},
    '{16'd1001,  40'd0},
    '{16'd909,   40'd0},
    '{16'd19999, 40'd0},
    '{16'd60000, 40'd0}
  };

  binary_to_decimal_ascii DUT (
    .clk         (clk),
    .rst         (rst),
    .value_valid (value_valid),
    .value_stall (value_stall),
    .value       (value),
    .char_valid  (char_valid),
    .char_stall  (char_stall),
    .char_code   (char_code),
    .last_char   (last_char)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // decimal digits of v, leading zeros dropped, units digit flagged last
  function automatic void push_decimal_chars(input logic [bdasc_pkg::VALUE_W-1:0] v);
    int unsigned weight [4] = '{10000, 1000, 100, 10};
    int unsigned rest;
    int unsigned dig [5];
    int          first;
    digit_char_t c;
    rest = v;
    for (int k = 0; k < 4; k++) begin
      dig[k] = rest / weight[k];
      rest   = rest % weight[k];
    end
    dig[4] = rest;
    first = 0;
    while (first < 4 && dig[first] == 0) first++;
    width_seen[5 - first]++;
    for (int k = first; k < 5; k++) begin
      c.code = bdasc_pkg::ASCII_ZERO + bdasc_pkg::CHAR_W'(dig[k]);
      c.last = (k == 4);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void push_typed_chars(input logic [39:0] txt);
    digit_char_t c;
    int          n;
    n = 0;
    for (int b = 4; b >= 0; b--) begin
      if (txt[b*8 +: 8] != 8'd0) begin
        c.code = txt[b*8 +: bdasc_pkg::CHAR_W];
        c.last = (b == 0);
        pending_chars.push_back(c);
        n++;
      end
    end
    width_seen[n]++;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 25);
  endfunction

  // random value, mostly with the digit count chosen first so short numbers are common
  function automatic logic [bdasc_pkg::VALUE_W-1:0] pick_value();
    int unsigned n;
    int unsigned lo;
    int unsigned hi;
    if ($urandom_range(0, 4) == 0) return bdasc_pkg::VALUE_W'($urandom_range(0, 65535));
    n  = $urandom_range(1, 5);
    lo = (n == 1) ? 0 : 10 ** (n - 1);
    hi = (n == 5) ? 65535 : 10 ** n - 1;
    return bdasc_pkg::VALUE_W'($urandom_range(lo, hi));
  endfunction

  task automatic send_value(input logic [bdasc_pkg::VALUE_W-1:0] v, input logic [39:0] txt);
    value       <= v;
    value_valid <= 1'b1;
    @(posedge clk);
    while (value_stall) @(posedge clk);
    if (txt != '0) push_typed_chars(txt);
    else push_decimal_chars(v);
    values_sent++;
  endtask

  // lowers valid only when a gap or a pause follows
  task automatic idle_after(input bit drain);
    int unsigned gap;
    gap = pick_gap();
    if (gap != 0 || drain) begin
      value_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      if (drain) begin
        while (pending_chars.size() != 0) @(posedge clk);
      end
    end
  endtask

  // char side back-pressure, mostly short bursts with a few long ones
  always @(posedge clk) begin
    if (rst || quiet) begin
      stall_left = 0;
      char_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      char_stall <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                : $urandom_range(8, 30);
      char_stall <= 1'b1;
    end else begin
      char_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : char_check
    digit_char_t want;
    if (!rst && char_valid && !char_stall) begin
      if (pending_chars.size() == 0) begin
        report_mismatch($sformatf("char 0x%0h last %0b with nothing pending",
                                  char_code, last_char));
      end else begin
        want = pending_chars.pop_front();
        chars_checked++;
        if (char_code !== want.code)
          report_mismatch($sformatf("char_code 0x%0h, want 0x%0h", char_code, want.code));
        if (last_char !== want.last)
          report_mismatch($sformatf("last_char %0b, want %0b on char 0x%0h",
                                    last_char, want.last, want.code));
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int i = 0; i < N_ROWS; i++) begin
      send_value(dir_rows[i].val, dir_rows[i].txt);
      idle_after(i == N_ROWS - 1);
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      quiet = (i >= 120 && i < 160);
      send_value(pick_value(), '0);
      idle_after(i == 80 || i == N_RANDOM - 1);
    end
    quiet = 1'b0;
    value_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);

    $display("sent %0d values (%0d from the table), checked %0d characters",
             values_sent, N_ROWS, chars_checked);
    $display("values by digit count 1..5: %0d %0d %0d %0d %0d",
             width_seen[1], width_seen[2], width_seen[3], width_seen[4], width_seen[5]);
    if (err_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
